// ===== hw/rtl/top_k_sampler_top_macros.svh =====
// Assertion macros used by the sampler top level.
`ifndef TOP_K_SAMPLER_TOP_MACROS_SVH
`define TOP_K_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTH
`define TKS_ASSERT(lbl, c, rn, p) \
	lbl: assert property (@(posedge c) disable iff (!rn) p) \
		else $error("sampler assertion failed");
`define TKS_ASSERT_NEXT(lbl, c, rn, a, b) \
	lbl: assert property (@(posedge c) disable iff (!rn) (a) |=> (b)) \
		else $error("sampler assertion failed");
`else
`define TKS_ASSERT(lbl, c, rn, p)
`define TKS_ASSERT_NEXT(lbl, c, rn, a, b)
`endif
`endif

// ===== hw/rtl/tks_pkg.sv =====
package tks_pkg;

	localparam int K_MAX     = 64;
	localparam int MAX_VOCAB = 8192;
	localparam int CNT_W     = $clog2(K_MAX);
	localparam int K_W       = 7;
	localparam int PROB_W    = 16;
	localparam int RF_W      = 16;
	localparam int IDX_W     = 13;
	localparam int ICNT_W    = $clog2(MAX_VOCAB) + 1;
	localparam int SUM_W     = PROB_W + CNT_W;
	localparam int PROD_W    = RF_W + SUM_W;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;
	localparam logic [K_W-1:0] TOP_K_RESET = K_W'(40);

	typedef struct packed {
		logic              valid;
		logic [PROB_W-1:0] prob;
		logic [IDX_W-1:0]  index;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic rot;
		logic clr;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/tks_cell.sv =====
module tks_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tks_pkg::cell_ctrl_t         ctrl,
	input  logic                        in_range,
	input  logic [tks_pkg::PROB_W-1:0]  new_prob,
	input  logic [tks_pkg::IDX_W-1:0]   new_index,
	input  tks_pkg::entry_t             prev_ent,
	input  logic                        prev_gt,
	input  tks_pkg::entry_t             next_ent,
	output tks_pkg::entry_t             ent,
	output logic                        gt
);

	logic                       valid_q;
	logic [tks_pkg::PROB_W-1:0] prob_q;
	logic [tks_pkg::IDX_W-1:0]  index_q;

	// The new value ranks above this entry when strictly larger; equal values keep
	// the earlier index in front.
	assign gt = in_range && (!valid_q || (new_prob > prob_q));

	assign ent.valid = valid_q;
	assign ent.prob  = prob_q;
	assign ent.index = index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (gt) begin
				valid_q <= prev_gt ? prev_ent.valid : 1'b1;
			end else if (!in_range) begin
				valid_q <= 1'b0;
			end
		end else if (ctrl.rot) begin
			valid_q <= next_ent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !ctrl.clr && gt) begin
			prob_q  <= prev_gt ? prev_ent.prob : new_prob;
			index_q <= prev_gt ? prev_ent.index : new_index;
		end else if (ctrl.rot && !ctrl.clr && !ctrl.ins) begin
			prob_q  <= next_ent.prob;
			index_q <= next_ent.index;
		end
	end

endmodule

// ===== hw/rtl/tks_chain.sv =====
module tks_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tks_pkg::cell_ctrl_t         ctrl,
	input  logic [tks_pkg::K_W-1:0]     k_eff,
	input  logic [tks_pkg::PROB_W-1:0]  new_prob,
	input  logic [tks_pkg::IDX_W-1:0]   new_index,
	output tks_pkg::entry_t             head
);

	tks_pkg::entry_t ent [tks_pkg::K_MAX];
	logic            gt  [tks_pkg::K_MAX];

	// Cell 0 holds the highest rank. Insertion shifts toward the tail; a rotation
	// moves every entry one cell toward the head and wraps the head to the tail.
	for (genvar i = 0; i < tks_pkg::K_MAX; i++) begin : g_cell
		tks_pkg::entry_t prev_ent;
		logic            prev_gt;
		logic            in_range;

		if (i == 0) begin : g_first
			assign prev_ent = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_rest
			assign prev_ent = ent[i-1];
			assign prev_gt  = gt[i-1];
		end

		assign in_range = tks_pkg::K_W'(i) < k_eff;

		tks_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.in_range  (in_range),
			.new_prob  (new_prob),
			.new_index (new_index),
			.prev_ent  (prev_ent),
			.prev_gt   (prev_gt),
			.next_ent  (ent[(i + 1) % tks_pkg::K_MAX]),
			.ent       (ent[i]),
			.gt        (gt[i])
		);
	end

	assign head = ent[0];

endmodule

// ===== hw/rtl/top_k_sampler_top.sv =====
// Streaming top-k sampler.
// Input stream: one probability per request in vocabulary order; its position in
// the vector is its token index. tlast marks the final probability and carries the
// random fraction used for the draw. Items past the vocabulary size are dropped.
// Output stream: one drawn token index per vector, held in an output register.
// Configuration: cfg_data sets top_k (0 acts as 1, values above 64 act as 64);
// write it only while the block is idle.
// Throughput: one probability per cycle while s_axis_tready is high; each item
// is inserted into the sorted row of 64 cells as it is taken. After the last
// request the draw occupies the block: it sums the kept values, forms the
// threshold with one multiply, scans the running sum until it reaches the
// threshold or the row ends, and posts the result, while s_axis_tready is low.
// Both passes rotate the cell row past its head, one entry a cycle.
// Reset empties the list, zeroes the item count and sets top_k to 40.
// A stalled receiver holds the result; the next vector is still taken in, and a
// further draw waits in its final cycle until the output register frees up.
`include "top_k_sampler_top_macros.svh"

module top_k_sampler_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tks_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // prob, random_fraction
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [tks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // token_index, zero pad
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tks_pkg::K_W-1:0]            cfg_data
);

	tks_pkg::state_t                state_q, state_d;
	logic [tks_pkg::K_W-1:0]        top_k_q;
	logic [tks_pkg::K_W-1:0]        k_eff;
	logic [tks_pkg::CNT_W-1:0]      cnt_q;
	logic [tks_pkg::ICNT_W-1:0]     item_cnt_q;
	logic [tks_pkg::SUM_W-1:0]      sum_q, thr_q, acc_q, acc_sum;
	logic [tks_pkg::RF_W-1:0]       rf_q;
	logic [tks_pkg::IDX_W-1:0]      last_idx_q, res_q, out_idx_q;
	logic [tks_pkg::PROD_W-1:0]     prod;
	logic                           out_valid_q;
	logic                           in_acc, head_incl, hit, last_cell, out_free, emit_load;
	tks_pkg::cell_ctrl_t            ctrl;
	tks_pkg::entry_t                head;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (top_k_q == '0) begin
			k_eff = tks_pkg::K_W'(1);
		end else if (top_k_q > tks_pkg::K_W'(tks_pkg::K_MAX)) begin
			k_eff = tks_pkg::K_W'(tks_pkg::K_MAX);
		end else begin
			k_eff = top_k_q;
		end
	end

	assign s_axis_tready = (state_q == tks_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign head_incl = head.valid && (tks_pkg::K_W'(cnt_q) < k_eff);
	assign acc_sum   = acc_q + tks_pkg::SUM_W'(head.prob);
	assign hit       = head_incl && (acc_sum >= thr_q);
	assign last_cell = (cnt_q == tks_pkg::CNT_W'(tks_pkg::K_MAX - 1));
	assign out_free  = !out_valid_q || m_axis_tready;
	assign emit_load = (state_q == tks_pkg::ST_EMIT) && out_free;
	assign prod      = tks_pkg::PROD_W'(rf_q) * tks_pkg::PROD_W'(sum_q);

	always_comb begin
		state_d  = state_q;
		ctrl.ins = in_acc && (item_cnt_q < tks_pkg::ICNT_W'(tks_pkg::MAX_VOCAB));
		ctrl.rot = 1'b0;
		ctrl.clr = emit_load;
		unique case (state_q)
			tks_pkg::ST_IDLE: begin
				if (in_acc && s_axis_tlast) begin
					state_d = tks_pkg::ST_SUM;
				end
			end
			tks_pkg::ST_SUM: begin
				ctrl.rot = 1'b1;
				if (last_cell) begin
					state_d = tks_pkg::ST_MUL;
				end
			end
			tks_pkg::ST_MUL: begin
				state_d = tks_pkg::ST_SCAN;
			end
			tks_pkg::ST_SCAN: begin
				ctrl.rot = 1'b1;
				if (hit || last_cell) begin
					state_d = tks_pkg::ST_EMIT;
				end
			end
			tks_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = tks_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tks_pkg::ST_IDLE;
			end
		endcase
	end

	tks_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.k_eff     (k_eff),
		.new_prob  (s_axis_tdata[tks_pkg::PROB_W-1:0]),
		.new_index (item_cnt_q[tks_pkg::IDX_W-1:0]),
		.head      (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tks_pkg::ST_IDLE;
			top_k_q     <= tks_pkg::TOP_K_RESET;
			cnt_q       <= '0;
			item_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				top_k_q <= cfg_data;
			end
			if (ctrl.rot) begin
				cnt_q <= cnt_q + tks_pkg::CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (emit_load) begin
				item_cnt_q <= '0;
			end else if (ctrl.ins) begin
				item_cnt_q <= item_cnt_q + tks_pkg::ICNT_W'(1);
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tks_pkg::ST_IDLE: begin
				rf_q  <= s_axis_tdata[tks_pkg::PROB_W +: tks_pkg::RF_W];
				sum_q <= '0;
			end
			tks_pkg::ST_SUM: begin
				if (head_incl) begin
					sum_q <= sum_q + tks_pkg::SUM_W'(head.prob);
				end
			end
			tks_pkg::ST_MUL: begin
				thr_q      <= prod[tks_pkg::PROD_W-1 -: tks_pkg::SUM_W];
				acc_q      <= '0;
				last_idx_q <= '0;
				res_q      <= '0;
			end
			tks_pkg::ST_SCAN: begin
				if (head_incl) begin
					acc_q      <= acc_sum;
					last_idx_q <= head.index;
				end
				// With no entry reaching the threshold, the last kept entry is drawn.
				if (hit || (last_cell && head_incl)) begin
					res_q <= head.index;
				end else if (last_cell) begin
					res_q <= last_idx_q;
				end
			end
			tks_pkg::ST_EMIT: begin
				if (out_free) begin
					out_idx_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tks_pkg::OUT_TDATA_W'(out_idx_q);

	`TKS_ASSERT_NEXT(a_last_starts_draw, clk, arst_n, in_acc && s_axis_tlast,
		state_q == tks_pkg::ST_SUM)
	`TKS_ASSERT(a_thr_below_sum, clk, arst_n,
		(state_q == tks_pkg::ST_SCAN) |-> (thr_q <= sum_q))
	`TKS_ASSERT(a_count_bounded, clk, arst_n,
		item_cnt_q <= tks_pkg::ICNT_W'(tks_pkg::MAX_VOCAB))
	`TKS_ASSERT_NEXT(a_emit_clears, clk, arst_n, emit_load,
		(item_cnt_q == '0) && !head.valid && m_axis_tvalid)

endmodule
